// ----- rtl/core/label_contour_tracer_core_macros.svh -----
// ----------------------------------------------------------------------------
// label contour tracer assertion macros
// clocked on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef LABEL_CONTOUR_TRACER_CORE_MACROS_SVH
`define LABEL_CONTOUR_TRACER_CORE_MACROS_SVH

// property checked at every rising clock edge out of reset
`define LCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen
`define LCT_ASSERT_NEVER(lbl, cond, msg) \
  `LCT_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/core/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// shared codes and controller/datapath interface types of the contour tracer
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  localparam int CFG_DW = 9;

  localparam logic [1:0] CFG_IMG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_FILL_RULE   = 2'd2;
  localparam logic [1:0] CFG_POINT_LIMIT = 2'd3;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_INIT    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;
  localparam logic [1:0] ACT_NEXT    = 2'd3;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [7:0] BORDER_PIXEL = 8'hFF;

  localparam logic [4:0] OP_IDLE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_PREP     = 5'd2;
  localparam logic [4:0] OP_PWRITE   = 5'd3;
  localparam logic [4:0] OP_BTOP     = 5'd4;
  localparam logic [4:0] OP_BBOT     = 5'd5;
  localparam logic [4:0] OP_BSIDE    = 5'd6;
  localparam logic [4:0] OP_INITACK  = 5'd7;
  localparam logic [4:0] OP_RESTACK  = 5'd8;
  localparam logic [4:0] OP_SCINIT   = 5'd9;
  localparam logic [4:0] OP_NONERES  = 5'd10;
  localparam logic [4:0] OP_RDPOS    = 5'd11;
  localparam logic [4:0] OP_SADV     = 5'd12;
  localparam logic [4:0] OP_FOUND    = 5'd13;
  localparam logic [4:0] OP_PROBE    = 5'd14;
  localparam logic [4:0] OP_FMOVE    = 5'd15;
  localparam logic [4:0] OP_ISO      = 5'd16;
  localparam logic [4:0] OP_PTXY1    = 5'd17;
  localparam logic [4:0] OP_PTX1Y    = 5'd18;
  localparam logic [4:0] OP_MINIT    = 5'd19;
  localparam logic [4:0] OP_MMOVE    = 5'd20;
  localparam logic [4:0] OP_PTXY     = 5'd21;
  localparam logic [4:0] OP_KINIT    = 5'd22;
  localparam logic [4:0] OP_KSTEP    = 5'd23;
  localparam logic [4:0] OP_STEPINC  = 5'd24;
  localparam logic [4:0] OP_SUM      = 5'd25;
  localparam logic [4:0] OP_DIVSTEP  = 5'd26;
  localparam logic [4:0] OP_DIVEND   = 5'd27;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic pos_lt_end;
    logic rd_flag;
    logic rd_match;
    logic cnt8;
    logic fill;
    logic a_top_last;
    logic a_bot_last;
    logic a_side_done;
    logic k_done;
    logic trace_done;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/lct_ram.sv -----
// ----------------------------------------------------------------------------
// lct_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lct_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/lct_ctrl.sv -----
// ----------------------------------------------------------------------------
// lct_ctrl
// sequencer for pixel writes, border framing, scan restart, run scan and moore trace
// ----------------------------------------------------------------------------
`default_nettype none

`include "label_contour_tracer_core_macros.svh"

module lct_ctrl
  import lct_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] action_i,
  output logic            busy_o,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PREP  = 5'd1;
  localparam logic [4:0] S_PWR   = 5'd2;
  localparam logic [4:0] S_BTOP  = 5'd3;
  localparam logic [4:0] S_BBOT  = 5'd4;
  localparam logic [4:0] S_BSIDE = 5'd5;
  localparam logic [4:0] S_REST  = 5'd6;
  localparam logic [4:0] S_SCI   = 5'd7;
  localparam logic [4:0] S_SO    = 5'd8;
  localparam logic [4:0] S_SOC   = 5'd9;
  localparam logic [4:0] S_SI    = 5'd10;
  localparam logic [4:0] S_SIC   = 5'd11;
  localparam logic [4:0] S_FP    = 5'd12;
  localparam logic [4:0] S_FPC   = 5'd13;
  localparam logic [4:0] S_ISO2  = 5'd14;
  localparam logic [4:0] S_ISO3  = 5'd15;
  localparam logic [4:0] S_MST   = 5'd16;
  localparam logic [4:0] S_MP    = 5'd17;
  localparam logic [4:0] S_MPC   = 5'd18;
  localparam logic [4:0] S_PTS   = 5'd19;
  localparam logic [4:0] S_KL    = 5'd20;
  localparam logic [4:0] S_MCHK  = 5'd21;
  localparam logic [4:0] S_SUM   = 5'd22;
  localparam logic [4:0] S_DIV   = 5'd23;

  logic [4:0] state_q, state_d;
  logic [1:0] act_q, act_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    cmd_o.op  = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          act_d    = action_i;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.op = OP_PREP;
        case (act_q)
          ACT_WRITE:   state_d = S_PWR;
          ACT_INIT:    state_d = S_BTOP;
          ACT_RESTART: state_d = S_REST;
          default:     state_d = S_SCI;
        endcase
      end
      S_PWR: begin
        cmd_o.op = OP_PWRITE;
        state_d  = S_IDLE;
      end
      S_BTOP: begin
        cmd_o.op = OP_BTOP;
        if (sts_i.a_top_last) state_d = S_BBOT;
      end
      S_BBOT: begin
        cmd_o.op = OP_BBOT;
        if (sts_i.a_bot_last) state_d = S_BSIDE;
      end
      S_BSIDE: begin
        if (sts_i.a_side_done) begin
          cmd_o.op = OP_INITACK;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_BSIDE;
        end
      end
      S_REST: begin
        cmd_o.op = OP_RESTACK;
        state_d  = S_IDLE;
      end
      S_SCI: begin
        cmd_o.op = OP_SCINIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.pos_lt_end || sts_i.div_done) begin
          cmd_o.op = OP_DIVEND;
          state_d  = S_SO;
        end else begin
          cmd_o.op = OP_DIVSTEP;
        end
      end
      S_SO: begin
        if (!sts_i.pos_lt_end) begin
          cmd_o.op = OP_NONERES;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_RDPOS;
          state_d  = S_SOC;
        end
      end
      S_SOC: begin
        if (!sts_i.rd_flag) begin
          cmd_o.op = OP_FOUND;
          state_d  = S_FP;
        end else begin
          cmd_o.op = OP_SADV;
          state_d  = S_SI;
        end
      end
      S_SI: begin
        cmd_o.op = OP_RDPOS;
        state_d  = S_SIC;
      end
      S_SIC: begin
        if (sts_i.rd_match && sts_i.pos_lt_end) begin
          cmd_o.op = OP_SADV;
          state_d  = S_SI;
        end else begin
          state_d = S_SO;
        end
      end
      S_FP: begin
        cmd_o.op = OP_PROBE;
        state_d  = S_FPC;
      end
      S_FPC: begin
        if (sts_i.rd_match) begin
          cmd_o.op = OP_FMOVE;
          state_d  = S_MST;
        end else if (sts_i.cnt8) begin
          cmd_o.op = OP_ISO;
          state_d  = sts_i.fill ? S_ISO2 : S_SUM;
        end else begin
          state_d = S_FP;
        end
      end
      S_ISO2: begin
        cmd_o.op = OP_PTXY1;
        state_d  = S_ISO3;
      end
      S_ISO3: begin
        cmd_o.op = OP_PTX1Y;
        state_d  = S_SUM;
      end
      S_MST: begin
        cmd_o.op = OP_MINIT;
        state_d  = S_MP;
      end
      S_MP: begin
        cmd_o.op = OP_PROBE;
        state_d  = S_MPC;
      end
      S_MPC: begin
        if (sts_i.rd_match) begin
          cmd_o.op = OP_MMOVE;
          state_d  = S_PTS;
        end else if (sts_i.cnt8) begin
          state_d = S_PTS;
        end else begin
          state_d = S_MP;
        end
      end
      S_PTS: begin
        if (sts_i.fill) begin
          cmd_o.op = OP_KINIT;
          state_d  = S_KL;
        end else begin
          cmd_o.op = OP_PTXY;
          state_d  = S_MCHK;
        end
      end
      S_KL: begin
        if (sts_i.k_done) begin
          state_d = S_MCHK;
        end else begin
          cmd_o.op = OP_KSTEP;
        end
      end
      S_MCHK: begin
        cmd_o.op = OP_STEPINC;
        state_d  = sts_i.trace_done ? S_SUM : S_MST;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_WRITE;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  `LCT_ASSERT(a_accept_goes_busy, (start_i && !busy_o) |=> busy_o, "accepted item did not start")
  `LCT_ASSERT(a_busy_from_start, $rose(busy_o) |-> $past(start_i), "busy without a start")
  `LCT_ASSERT_NEVER(a_kloop_plain, (state_q == S_KL) && !sts_i.fill, "corner loop in plain mode")

endmodule

`default_nettype wire

// ----- rtl/core/lct_dp.sv -----
// ----------------------------------------------------------------------------
// lct_dp
// pixel store, position and direction registers, neighbour math, result regs
// ----------------------------------------------------------------------------
`default_nettype none

`include "label_contour_tracer_core_macros.svh"

module lct_dp
  import lct_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_POINTS = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  input  wire logic [7:0]        pixel_x_i,
  input  wire logic [7:0]        pixel_y_i,
  input  wire logic [6:0]        pixel_label_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic                   result_valid_o,
  output logic [1:0]             kind_o,
  output logic [8:0]             point_x_o,
  output logic [8:0]             point_y_o,
  output logic [6:0]             label_id_o,
  output logic [5:0]             point_count_o,
  output logic                   last_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int SW = PW + 3;
  localparam int LW = PW + 2;

  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic          fill_q;
  logic [5:0]    lim_q;

  logic [7:0]    in_x_q, in_y_q;
  logic [6:0]    in_lab_q;
  logic [PW-1:0] frame_q, end_w;
  logic [AW-1:0] waddr_q, a_q;
  logic          side_q;

  logic [AW-1:0] scan_q, pos_q, cur_q, stop_q, rem_q;
  logic [WW-1:0] x_q, cx_q;
  logic [HW-1:0] y_q, cy_q;
  logic [6:0]    lab_q;
  logic [2:0]    dir_q, idir_q, odir_q, stopdir_q, k_q;
  logic [3:0]    cnt_q;
  logic          tl_q;
  logic [SW-1:0] steps_q;
  logic [5:0]    npts_q;

  logic          rv_q, rv_d;
  logic [1:0]    kind_q, kind_d;
  logic [8:0]    ox_q, ox_d, oy_q, oy_d;
  logic [6:0]    olab_q, olab_d;
  logic [5:0]    ocnt_q, ocnt_d;
  logic          olast_q, olast_d;
  logic          k_emit;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  lct_ram #(
    .DW   (8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign end_w = PW'(32'(frame_q) - 32'(w_q));

  // neighbour of the current pixel in direction dir+1
  logic [2:0]           ndir;
  logic signed [1:0]    dx, dy, carry;
  logic signed [LW-1:0] ws, fs, dlin, lin;
  logic signed [WW+1:0] xs;
  logic signed [HW+1:0] ys, hs;
  logic [AW-1:0]        ncur;
  logic [WW-1:0]        nx;
  logic [HW-1:0]        ny;

  always_comb begin
    ndir = dir_q + 3'd1;
    ws   = $signed(LW'(w_q));
    fs   = $signed(LW'(frame_q));
    hs   = $signed((HW+2)'(h_q));
    case (ndir)
      3'd0:    begin dx = -2'sd1; dy =  2'sd0; end
      3'd1:    begin dx = -2'sd1; dy =  2'sd1; end
      3'd2:    begin dx =  2'sd0; dy =  2'sd1; end
      3'd3:    begin dx =  2'sd1; dy =  2'sd1; end
      3'd4:    begin dx =  2'sd1; dy =  2'sd0; end
      3'd5:    begin dx =  2'sd1; dy = -2'sd1; end
      3'd6:    begin dx =  2'sd0; dy = -2'sd1; end
      default: begin dx = -2'sd1; dy = -2'sd1; end
    endcase
    case (dy)
      2'sd1:   dlin = ws + LW'(dx);
      -2'sd1:  dlin = LW'(dx) - ws;
      default: dlin = LW'(dx);
    endcase
    lin = $signed(LW'(pos_q)) + dlin;
    if (lin < 0) begin
      lin = lin + fs;
    end else if (lin >= fs) begin
      lin = lin - fs;
    end
    ncur = AW'(lin);
    xs = $signed((WW+2)'(x_q)) + dx;
    if (xs < 0) begin
      nx    = WW'(32'(w_q) - 1);
      carry = -2'sd1;
    end else if (xs == $signed((WW+2)'(w_q))) begin
      nx    = '0;
      carry = 2'sd1;
    end else begin
      nx    = WW'(xs);
      carry = 2'sd0;
    end
    ys = $signed((HW+2)'(y_q)) + dy + carry;
    if (ys < 0) begin
      ys = ys + hs;
    end else if (ys >= hs) begin
      ys = ys - hs;
    end
    ny = HW'(ys);
  end

  logic pix_ok;
  assign pix_ok = (32'(in_x_q) < 32'(w_q)) && (32'(in_y_q) < 32'(h_q));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_q;
    ram_wdata = BORDER_PIXEL;
    ram_raddr = (cmd_i.op == OP_PROBE) ? ncur : pos_q;
    case (cmd_i.op)
      OP_PWRITE: begin
        ram_we    = pix_ok;
        ram_waddr = waddr_q;
        ram_wdata = {1'b0, in_lab_q};
      end
      OP_BTOP, OP_BBOT, OP_BSIDE: ram_we = 1'b1;
      OP_ISO: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = {1'b1, lab_q};
      end
      OP_MMOVE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = {1'b1, lab_q};
      end
      default: ram_we = 1'b0;
    endcase
  end

  logic [SW-1:0] maxsteps;
  assign maxsteps = {frame_q, 3'b000};

  always_comb begin
    sts_o.pos_lt_end  = (PW'(pos_q) < end_w);
    sts_o.rd_flag     = ram_rdata[7];
    sts_o.rd_match    = (ram_rdata[6:0] == lab_q);
    sts_o.cnt8        = (cnt_q == 4'd8);
    sts_o.fill        = fill_q;
    sts_o.a_top_last  = (32'(a_q) == 32'(w_q) - 1);
    sts_o.a_bot_last  = (32'(a_q) == 32'(frame_q) - 1);
    sts_o.a_side_done = (PW'(a_q) >= end_w);
    sts_o.k_done      = (k_q == odir_q);
    sts_o.trace_done  = ((pos_q == stop_q) && (dir_q == stopdir_q))
                        || (SW'(steps_q + 1'b1) >= maxsteps);
    sts_o.div_done    = (32'(rem_q) < 32'(w_q));
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WW'(MAX_WIDTH < 256 ? MAX_WIDTH : 256);
      h_q    <= HW'(MAX_HEIGHT < 256 ? MAX_HEIGHT : 256);
      fill_q <= 1'b0;
      lim_q  <= 6'(MAX_POINTS < 63 ? MAX_POINTS : 63);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMG_WIDTH: begin
          if (32'(cfg_data_i) < 32'd3) w_q <= WW'(3);
          else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) w_q <= WW'(MAX_WIDTH);
          else w_q <= WW'(cfg_data_i);
        end
        CFG_IMG_HEIGHT: begin
          if (32'(cfg_data_i) < 32'd3) h_q <= HW'(3);
          else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) h_q <= HW'(MAX_HEIGHT);
          else h_q <= HW'(cfg_data_i);
        end
        CFG_FILL_RULE: fill_q <= cfg_data_i[0];
        CFG_POINT_LIMIT: begin
          if (32'(cfg_data_i[5:0]) > 32'(MAX_POINTS)) lim_q <= 6'(MAX_POINTS);
          else lim_q <= cfg_data_i[5:0];
        end
        default: fill_q <= fill_q;
      endcase
    end
  end

  // corner point taken at this direction step
  assign k_emit = (!tl_q && (k_q == 3'd0 || k_q == 3'd6)) || k_q == 3'd2 || k_q == 3'd4;

  always_comb begin
    case (cmd_i.op)
      OP_INITACK, OP_RESTACK, OP_PWRITE, OP_NONERES, OP_SUM: rv_d = 1'b1;
      OP_ISO, OP_PTXY1, OP_PTX1Y, OP_PTXY: rv_d = (npts_q < lim_q);
      OP_KSTEP: rv_d = k_emit && (npts_q < lim_q);
      default: rv_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      rv_q   <= 1'b0;
      npts_q <= '0;
      cnt_q  <= '0;
    end else begin
      rv_q <= rv_d;
      case (cmd_i.op)
        OP_INITACK: scan_q <= AW'(32'(w_q) + 1);
        OP_RESTACK: scan_q <= '0;
        OP_NONERES: begin
          if (PW'(scan_q) < end_w) scan_q <= pos_q;
        end
        OP_FOUND: begin
          scan_q <= pos_q;
          npts_q <= '0;
          cnt_q  <= '0;
        end
        OP_PROBE: cnt_q <= cnt_q + 4'd1;
        OP_MINIT: cnt_q <= '0;
        OP_ISO, OP_PTXY1, OP_PTX1Y, OP_PTXY, OP_KSTEP: begin
          if (rv_d) npts_q <= npts_q + 6'd1;
        end
        OP_SUM: scan_q <= scan_q + 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        in_x_q   <= pixel_x_i;
        in_y_q   <= pixel_y_i;
        in_lab_q <= pixel_label_i;
      end
      OP_PREP: begin
        frame_q <= PW'(32'(w_q) * 32'(h_q));
        waddr_q <= AW'(32'(in_y_q) * 32'(w_q) + 32'(in_x_q));
        a_q     <= '0;
      end
      OP_BTOP: begin
        if (sts_o.a_top_last) a_q <= AW'(end_w);
        else a_q <= a_q + 1'b1;
      end
      OP_BBOT: begin
        if (sts_o.a_bot_last) begin
          a_q    <= AW'(w_q);
          side_q <= 1'b0;
        end else begin
          a_q <= a_q + 1'b1;
        end
      end
      OP_BSIDE: begin
        a_q    <= side_q ? a_q + 1'b1 : AW'(32'(a_q) + 32'(w_q) - 1);
        side_q <= !side_q;
      end
      OP_SCINIT: begin
        pos_q <= scan_q;
        rem_q <= scan_q;
        y_q   <= '0;
      end
      // row and column of the scan position by repeated subtraction
      OP_DIVSTEP: begin
        rem_q <= rem_q - AW'(w_q);
        y_q   <= y_q + 1'b1;
      end
      OP_DIVEND: x_q <= WW'(rem_q);
      OP_SADV: begin
        lab_q <= ram_rdata[6:0];
        pos_q <= pos_q + 1'b1;
        if (32'(x_q) + 1 == 32'(w_q)) begin
          x_q <= '0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      OP_FOUND: begin
        lab_q <= ram_rdata[6:0];
        dir_q <= '0;
      end
      OP_PROBE: begin
        dir_q <= ndir;
        cur_q <= ncur;
        cx_q  <= nx;
        cy_q  <= ny;
      end
      OP_FMOVE: begin
        pos_q     <= cur_q;
        x_q       <= cx_q;
        y_q       <= cy_q;
        dir_q     <= dir_q + 3'd4;
        stop_q    <= cur_q;
        stopdir_q <= dir_q + 3'd4;
        steps_q   <= '0;
      end
      OP_MINIT: begin
        idir_q <= dir_q;
        odir_q <= dir_q;
      end
      OP_MMOVE: begin
        pos_q  <= cur_q;
        x_q    <= cx_q;
        y_q    <= cy_q;
        odir_q <= dir_q;
        dir_q  <= dir_q + 3'd4;
      end
      OP_KINIT: begin
        k_q  <= idir_q + 3'd1;
        tl_q <= 1'b0;
      end
      OP_KSTEP: begin
        k_q <= k_q + 3'd1;
        if (!tl_q && (k_q == 3'd0 || k_q == 3'd6)) tl_q <= 1'b1;
        else if (k_q == 3'd2 || k_q == 3'd4) tl_q <= 1'b0;
      end
      OP_STEPINC: steps_q <= steps_q + 1'b1;
      default: side_q <= side_q;
    endcase
  end

  // result payload
  always_comb begin
    kind_d  = KIND_ACK;
    ox_d    = '0;
    oy_d    = '0;
    olab_d  = '0;
    ocnt_d  = '0;
    olast_d = 1'b1;
    case (cmd_i.op)
      OP_NONERES: kind_d = KIND_NONE;
      OP_ISO, OP_PTXY: begin
        kind_d  = KIND_POINT;
        ox_d    = 9'(x_q);
        oy_d    = 9'(y_q);
        olast_d = 1'b0;
      end
      OP_PTXY1: begin
        kind_d  = KIND_POINT;
        ox_d    = 9'(x_q);
        oy_d    = 9'(32'(y_q) + 1);
        olast_d = 1'b0;
      end
      OP_PTX1Y: begin
        kind_d  = KIND_POINT;
        ox_d    = 9'(32'(x_q) + 1);
        oy_d    = 9'(y_q);
        olast_d = 1'b0;
      end
      OP_KSTEP: begin
        kind_d  = KIND_POINT;
        olast_d = 1'b0;
        ox_d    = (k_q == 3'd4) ? 9'(32'(x_q) + 1) : 9'(x_q);
        oy_d    = (k_q == 3'd2) ? 9'(32'(y_q) + 1) : 9'(y_q);
      end
      OP_SUM: begin
        kind_d = KIND_SUMMARY;
        olab_d = lab_q;
        ocnt_d = npts_q;
      end
      default: olast_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olab_q  <= olab_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign result_valid_o = rv_q;
  assign kind_o         = kind_q;
  assign point_x_o      = ox_q;
  assign point_y_o      = oy_q;
  assign label_id_o     = olab_q;
  assign point_count_o  = ocnt_q;
  assign last_o         = olast_q;

  `LCT_ASSERT(a_point_not_last, (rv_q && kind_q == KIND_POINT) |-> !olast_q, "point marked last")
  `LCT_ASSERT(a_probe_count, (cmd_i.op == OP_PROBE) |-> (cnt_q < 4'd8), "more than eight probes")
  `LCT_ASSERT_NEVER(a_count_over_limit, npts_q > 6'(MAX_POINTS), "point count above maximum")

endmodule

`default_nettype wire

// ----- rtl/core/label_contour_tracer_core.sv -----
// label contour tracer core, one input transfer at a time, busy until its last result
// write, restart: the result strobe follows the prep and then the write or ack state, busy drops with it
// init: top row, bottom row then side columns, one border write per cycle on the single write port
// next: the scan row is found by repeated subtraction, then pixels are scanned and neighbours probed,
// and each trace step may add corner output; results never stalled by the receiver
// reset clears control and scan position, sets config to defaults, the pixel store is not cleared
// ----------------------------------------------------------------------------
// label_contour_tracer_core
// traces outer contours of labelled regions held in a pixel store
// ----------------------------------------------------------------------------
`default_nettype none

module label_contour_tracer_core
  import lct_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_POINTS = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [7:0]        pixel_x_i,
  input  wire logic [7:0]        pixel_y_i,
  input  wire logic [6:0]        pixel_label_i,
  output logic                   result_valid_o,
  output logic [1:0]             kind_o,
  output logic [8:0]             point_x_o,
  output logic [8:0]             point_y_o,
  output logic [6:0]             label_id_o,
  output logic [5:0]             point_count_o,
  output logic                   last_o
);

  cmd_t cmd;
  sts_t sts;

  lct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .action_i(action_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  lct_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .pixel_label_i (pixel_label_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_valid_o(result_valid_o),
    .kind_o        (kind_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .label_id_o    (label_id_o),
    .point_count_o (point_count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// label contour tracer testbench
// fills small labelled images pixel by pixel, frames most of them and pulls contours
// one by one; every result is checked against a contour predictor kept here
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import lct_pkg::*;

  typedef struct {
    logic [1:0] act;
    logic [7:0] x;
    logic [7:0] y;
    logic [6:0] lab;
  } req_t;

  typedef struct {
    logic [1:0] kind;
    logic [8:0] px;
    logic [8:0] py;
    logic [6:0] lab;
    logic [5:0] cnt;
    logic       last;
  } res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        action_i = ACT_WRITE;
  logic [7:0]        pixel_x_i = '0;
  logic [7:0]        pixel_y_i = '0;
  logic [6:0]        pixel_label_i = '0;
  logic              result_valid_o;
  logic [1:0]        kind_o;
  logic [8:0]        point_x_o;
  logic [8:0]        point_y_o;
  logic [6:0]        label_id_o;
  logic [5:0]        point_count_o;
  logic              last_o;

  label_contour_tracer_core dut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  // predictor state
  logic [7:0] pix_mem [0:65535];
  int unsigned scan_pos, img_w, img_h, fill_mode, pt_limit;
  int unsigned pt_x [$], pt_y [$];

  req_t pending_reqs [$];
  res_t expected_res [$];
  int   errors, n_reqs, n_contours, n_points, n_checked;
  int   burst_left, gap_left;

  function automatic int unsigned nbr(int unsigned pos, int unsigned d, int unsigned w,
                                      int unsigned frame);
    int delta;
    case (d & 7)
      0: delta = -1;
      1: delta = int'(w) - 1;
      2: delta = int'(w);
      3: delta = int'(w) + 1;
      4: delta = 1;
      5: delta = 1 - int'(w);
      6: delta = -int'(w);
      default: delta = -int'(w) - 1;
    endcase
    return int'(pos + frame) + delta;
  endfunction

  function automatic void add_pt(int unsigned x, int unsigned y);
    if (pt_x.size() < pt_limit) begin
      pt_x.push_back(x);
      pt_y.push_back(y);
    end
  endfunction

  function automatic void trace_contour(int unsigned w, int unsigned frame,
                                        int unsigned start, logic [6:0] lab);
    int unsigned pos, dir, cur, stop_pos, stop_dir, steps, idir, odir, x, y, k;
    bit found, tl;
    pos = start;
    dir = 0;
    found = 0;
    for (int i = 0; i < 8; i++) begin
      dir = (dir + 1) & 7;
      cur = nbr(pos, dir, w, frame) % frame;
      if (pix_mem[cur][6:0] == lab) begin
        pos = cur;
        dir = (dir + 4) & 7;
        found = 1;
        break;
      end
    end
    if (!found) begin
      pix_mem[pos][7] = 1'b1;
      add_pt(pos % w, pos / w);
      if (fill_mode != 0) begin
        add_pt(pos % w, pos / w + 1);
        add_pt(pos % w + 1, pos / w);
      end
      return;
    end
    stop_pos = pos;
    stop_dir = dir;
    steps = 0;
    forever begin
      idir = dir;
      odir = dir;
      for (int i = 0; i < 8; i++) begin
        dir = (dir + 1) & 7;
        cur = nbr(pos, dir, w, frame) % frame;
        if (pix_mem[cur][6:0] == lab) begin
          pix_mem[cur][7] = 1'b1;
          pos = cur;
          odir = dir;
          dir = (dir + 4) & 7;
          break;
        end
      end
      x = pos % w;
      y = pos / w;
      if (fill_mode != 0) begin
        tl = 0;
        k = (idir + 1) & 7;
        while (k != odir) begin
          if (!tl && k == 0) begin add_pt(x, y); tl = 1; end
          if (k == 2) begin add_pt(x, y + 1); tl = 0; end
          if (k == 4) begin add_pt(x + 1, y); tl = 0; end
          if (!tl && k == 6) begin add_pt(x, y); tl = 1; end
          k = (k + 1) & 7;
        end
      end else begin
        add_pt(x, y);
      end
      if (pos == stop_pos && dir == stop_dir) break;
      steps++;
      if (steps >= 8 * frame) break;
    end
  endfunction

  function automatic void push_res(logic [1:0] kind, int unsigned x, int unsigned y,
                                   logic [6:0] lab, int unsigned cnt, bit last);
    res_t r;
    r.kind = kind;
    r.px = x[8:0];
    r.py = y[8:0];
    r.lab = lab;
    r.cnt = cnt[5:0];
    r.last = last;
    expected_res.push_back(r);
  endfunction

  function automatic void predict_req(req_t q);
    int unsigned w, h, frame, last_row, pos;
    logic [6:0] lab;
    logic [7:0] v;
    w = img_w;
    h = img_h;
    frame = w * h;
    last_row = w * (h - 1);
    case (q.act)
      ACT_WRITE: begin
        if (q.x < w && q.y < h) pix_mem[q.y * w + q.x] = {1'b0, q.lab};
        push_res(KIND_ACK, 0, 0, 0, 0, 1);
      end
      ACT_INIT: begin
        for (int unsigned i = 0; i < w; i++) begin
          pix_mem[i] = BORDER_PIXEL;
          pix_mem[last_row + i] = BORDER_PIXEL;
        end
        for (int unsigned i = 1; i + 1 < h; i++) begin
          pix_mem[i * w] = BORDER_PIXEL;
          pix_mem[i * w + w - 1] = BORDER_PIXEL;
        end
        scan_pos = w + 1;
        push_res(KIND_ACK, 0, 0, 0, 0, 1);
      end
      ACT_RESTART: begin
        scan_pos = 0;
        push_res(KIND_ACK, 0, 0, 0, 0, 1);
      end
      default: begin
        pos = scan_pos;
        lab = '0;
        while (pos < last_row) begin
          v = pix_mem[pos];
          lab = v[6:0];
          if (!v[7]) break;
          do begin
            pos++;
            if (pix_mem[pos][6:0] != lab) break;
          end while (pos < last_row);
        end
        if (pos >= last_row) begin
          if (scan_pos < last_row) scan_pos = pos;
          push_res(KIND_NONE, 0, 0, 0, 0, 1);
        end else begin
          pt_x.delete();
          pt_y.delete();
          trace_contour(w, frame, pos, lab);
          scan_pos = pos + 1;
          foreach (pt_x[i]) push_res(KIND_POINT, pt_x[i], pt_y[i], 0, 0, 0);
          push_res(KIND_SUMMARY, 0, 0, lab, pt_x.size(), 1);
          n_contours++;
          n_points += pt_x.size();
        end
      end
    endcase
  endfunction

  // driver: bursts of transfers with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    req_t q;
    bit took;
    if (!rst_ni) begin
      start_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      took = start_i && !busy_o;
      if (took) begin
        q.act = action_i;
        q.x = pixel_x_i;
        q.y = pixel_y_i;
        q.lab = pixel_label_i;
        predict_req(q);
        n_reqs++;
      end
      if (start_i && !took) begin
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        action_i <= q.act;
        pixel_x_i <= q.x;
        pixel_y_i <= q.y;
        pixel_label_i <= q.lab;
        start_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result kind %0d x %0d y %0d", $time, kind_o,
                 point_x_o, point_y_o);
        errors++;
      end else begin
        e = expected_res.pop_front();
        n_checked++;
        if (kind_o !== e.kind || point_x_o !== e.px || point_y_o !== e.py ||
            label_id_o !== e.lab || point_count_o !== e.cnt || last_o !== e.last) begin
          $display("%0t: mismatch expected k%0d x%0d y%0d l%0d n%0d last%0d", $time,
                   e.kind, e.px, e.py, e.lab, e.cnt, e.last);
          $display("%0t:          actual   k%0d x%0d y%0d l%0d n%0d last%0d", $time,
                   kind_o, point_x_o, point_y_o, label_id_o, point_count_o, last_o);
          errors++;
        end
      end
    end
  end

  task automatic add_req(logic [1:0] act, int unsigned x, int unsigned y, int unsigned lab);
    req_t q;
    q.act = act;
    q.x = x[7:0];
    q.y = y[7:0];
    q.lab = lab[6:0];
    pending_reqs.push_back(q);
  endtask

  task automatic wait_idle();
    while (!(pending_reqs.size() == 0 && !start_i && expected_res.size() == 0 && !busy_o))
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IMG_WIDTH:   img_w = (val % 512 < 3) ? 3 : (val % 512 > 256) ? 256 : val % 512;
      CFG_IMG_HEIGHT:  img_h = (val % 512 < 3) ? 3 : (val % 512 > 256) ? 256 : val % 512;
      CFG_FILL_RULE:   fill_mode = val & 1;
      default:         pt_limit = val % 64;
    endcase
  endtask

  // one image: settings, full fill, usually framing, then contour pulls
  task automatic run_image(int unsigned w_raw, int unsigned h_raw, int unsigned fill,
                           int unsigned limit, int unsigned n_next);
    int unsigned lab;
    wait_idle();
    write_reg(CFG_IMG_WIDTH, w_raw);
    write_reg(CFG_IMG_HEIGHT, h_raw);
    write_reg(CFG_FILL_RULE, fill);
    write_reg(CFG_POINT_LIMIT, limit);
    for (int unsigned y = 0; y < img_h; y++)
      for (int unsigned x = 0; x < img_w; x++) begin
        lab = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 3);
        add_req(ACT_WRITE, x, y, lab);
        if ($urandom_range(0, 40) == 0)
          add_req(ACT_WRITE, $urandom_range(0, 255), $urandom_range(img_h, 255), 127);
      end
    if ($urandom_range(0, 4) != 0) add_req(ACT_INIT, 0, 0, 0);
    for (int unsigned i = 0; i < n_next; i++) begin
      case ($urandom_range(0, 9))
        0: add_req(ACT_RESTART, 0, 0, 0);
        1: add_req(ACT_INIT, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 127));
        2: add_req(ACT_WRITE, $urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1),
                   $urandom_range(0, 127));
        default: add_req(ACT_NEXT, 0, 0, 0);
      endcase
    end
  endtask

  initial begin
    img_w = 256;
    img_h = 256;
    fill_mode = 0;
    pt_limit = 63;
    scan_pos = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // single interior pixel, isolated and not, both output modes, zero limit
    run_image(0, 3, 1, 63, 3);
    run_image(4, 4, 0, 0, 4);
    run_image(5, 5, 1, 2, 6);
    run_image(1, 4, 0, 63, 8);
    run_image(9, 2, 1, 63, 8);
    for (int p = 0; p < 4; p++)
      run_image($urandom_range(3, 7), $urandom_range(3, 7), $urandom_range(0, 1),
                $urandom_range(0, 63), $urandom_range(10, 30));
    run_image(6, 6, 0, 63, 10);
    wait_idle();

    $display("%0d transfers, %0d contours traced with %0d points, %0d results checked",
             n_reqs, n_contours, n_points, n_checked);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
